// File: design/abba_pkg.sv
package abba_pkg;

    localparam int LEN_W  = 41;
    localparam int ADDR_W = 48;
    localparam int LOG_W  = 6;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_INVALID     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_NOSPACE     = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [2:0] CFG_STEER_BASE      = 3'd0;
    localparam logic [2:0] CFG_STEER_LOG_SIZE  = 3'd1;
    localparam logic [2:0] CFG_MODIFY_BASE     = 3'd2;
    localparam logic [2:0] CFG_MODIFY_LOG_SIZE = 3'd3;
    localparam logic [2:0] CFG_LOG_BLOCK       = 3'd4;

    localparam logic [5:0] LOG_BLOCK_RST = 6'd12;

    typedef struct packed {
        logic load_req;
        logic check;
        logic prep;
        logic set_nospace;
        logic rd_scan;
        logic scan_step;
        logic rd_rmw;
        logic wr_rmw;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic err;
        logic is_free;
        logic range_empty;
        logic no_fit;
        logic found;
        logic scan_end;
        logic word_end;
        logic rmw_last;
        logic out_free;
    } sts_t;

endpackage

// File: design/abba_dp.sv
module abba_dp #(
    parameter int MAP_BITS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  abba_pkg::cmd_t      cmd,
    output abba_pkg::sts_t      sts,
    input  logic [2:0]          s_tuser,
    input  logic [95:0]         s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [55:0]         m_tdata,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_wdata
);

    localparam int WORDS = (MAP_BITS + 31) / 32;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW    = WA + 5;
    localparam int NW    = IW + 2;
    localparam int DEPTH = 2 * (2 ** WA);
    localparam logic [NW-1:0] MAXB_CAP = NW'(MAP_BITS);

    // configuration
    logic [47:0] steer_base_reg, modify_base_reg;
    logic [5:0]  steer_log_size_reg, modify_log_size_reg, log_block_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steer_base_reg      <= '0;
            steer_log_size_reg  <= '0;
            modify_base_reg     <= '0;
            modify_log_size_reg <= '0;
            log_block_reg       <= abba_pkg::LOG_BLOCK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                abba_pkg::CFG_STEER_BASE:      steer_base_reg      <= cfg_wdata;
                abba_pkg::CFG_STEER_LOG_SIZE:  steer_log_size_reg  <= cfg_wdata[5:0];
                abba_pkg::CFG_MODIFY_BASE:     modify_base_reg     <= cfg_wdata;
                abba_pkg::CFG_MODIFY_LOG_SIZE: modify_log_size_reg <= cfg_wdata[5:0];
                abba_pkg::CFG_LOG_BLOCK:       log_block_reg       <= cfg_wdata[5:0];
                default:
                begin
                end
            endcase
        end
    end

    // request
    logic        kind_reg;
    logic [1:0]  pool_reg;
    logic [40:0] len_reg;
    logic [5:0]  lalign_reg;
    logic [47:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kind_reg   <= s_tuser[0];
            pool_reg   <= s_tuser[2:1];
            len_reg    <= s_tdata[40:0];
            lalign_reg <= s_tdata[46:41];
            addr_reg   <= s_tdata[94:47];
        end
    end

    // request decode
    logic [40:0] lmask;
    logic        len_bad;
    logic [47:0] sel_base;
    logic [5:0]  sel_lsize;
    logic [1:0]  err_code;
    logic [NW-1:0] maxb;
    logic [5:0]  e2;
    logic [63:0] first64;
    logic [41:0] nfree;

    always_comb
    begin
        logic [6:0]    e7;
        logic [NW-1:0] p;
        logic [5:0]    la;
        lmask     = (41'd1 << log_block_reg) - 41'd1;
        len_bad   = (len_reg == '0) || ((len_reg & (len_reg - 41'd1)) != '0)
                    || ((len_reg & lmask) != '0);
        sel_base  = pool_reg[0] ? modify_base_reg : steer_base_reg;
        sel_lsize = pool_reg[0] ? modify_log_size_reg : steer_log_size_reg;
        if (kind_reg == abba_pkg::KIND_ALLOC && len_bad)
            err_code = abba_pkg::ST_INVALID;
        else if (pool_reg[1])
            err_code = abba_pkg::ST_INVALID;
        else if (sel_base == '0)
            err_code = abba_pkg::ST_UNSUPPORTED;
        else
            err_code = abba_pkg::ST_OK;
        e7 = {1'b0, sel_lsize} - {1'b0, log_block_reg};
        p  = NW'(1) << e7[5:0];
        if (e7[6])
            maxb = '0;
        else if (e7[5:0] > 6'(IW))
            maxb = MAXB_CAP;
        else
            maxb = (p > MAXB_CAP) ? MAXB_CAP : p;
        la      = (lalign_reg < log_block_reg) ? log_block_reg : lalign_reg;
        e2      = la - log_block_reg;
        first64 = ({16'b0, addr_reg} - {16'b0, sel_base}) >> log_block_reg;
        nfree   = {1'b0, len_reg >> log_block_reg} + 42'(|(len_reg & lmask));
    end

    logic [1:0]    status_reg;
    logic [47:0]   base_reg, gaddr_reg;
    logic [NW-1:0] maxb_reg;
    logic [40:0]   num41_reg;
    logic [5:0]    e2_reg;
    logic [63:0]   first_reg;
    logic [41:0]   nfree_reg;

    // scan and update
    logic [NW-1:0] lo_reg, hi_reg, i_reg, c_reg, num_reg;
    logic          c_over_reg;
    logic [WA-1:0] w_reg;
    logic [31:0]   rd_reg;
    logic          rv_reg;
    logic [31:0]   rdata;

    logic [64:0]   hi65;
    logic [NW-1:0] lo_cl, hi_cl;
    logic          al_over;
    logic [NW-1:0] amask, up;
    logic          cur_bit, found;
    logic [NW-1:0] hwm1;
    logic [31:0]   wmask, wdata;

    always_comb
    begin
        logic [NW-1:0] idx;
        hi65    = {1'b0, first_reg} + 65'(nfree_reg);
        lo_cl   = (first_reg >= 64'(maxb_reg)) ? maxb_reg : first_reg[NW-1:0];
        hi_cl   = (hi65 >= 65'(maxb_reg)) ? maxb_reg : hi65[NW-1:0];
        al_over = e2_reg > 6'(IW);
        amask   = (NW'(1) << e2_reg) - NW'(1);
        up      = (i_reg + NW'(1) + amask) & ~amask;
        rdata   = rv_reg ? rd_reg : '0;
        cur_bit = rdata[i_reg[4:0]];
        found   = !cur_bit && !c_over_reg
                  && (({1'b0, c_reg} + {1'b0, num_reg}) == ({1'b0, i_reg} + (NW+1)'(1)));
        hwm1    = hi_reg - NW'(1);
        for (int j = 0; j < 32; j++)
        begin
            idx      = NW'({w_reg, 5'(j)});
            wmask[j] = (idx >= lo_reg) && (idx < hi_reg);
        end
        wdata = (kind_reg == abba_pkg::KIND_FREE) ? (rdata & ~wmask) : (rdata | wmask);
    end

    assign sts.err         = status_reg != abba_pkg::ST_OK;
    assign sts.is_free     = kind_reg == abba_pkg::KIND_FREE;
    assign sts.range_empty = !(lo_cl < hi_cl);
    assign sts.no_fit      = (maxb_reg == '0) || (num41_reg > 41'(maxb_reg));
    assign sts.found       = found;
    assign sts.scan_end    = ((i_reg + NW'(1)) == maxb_reg) && !found;
    assign sts.word_end    = i_reg[4:0] == 5'd31;
    assign sts.rmw_last    = w_reg == hwm1[IW-1:5];

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            status_reg <= err_code;
            base_reg   <= sel_base;
            maxb_reg   <= maxb;
            num41_reg  <= len_reg >> log_block_reg;
            e2_reg     <= e2;
            first_reg  <= first64;
            nfree_reg  <= nfree;
            gaddr_reg  <= '0;
        end
        if (cmd.set_nospace)
            status_reg <= abba_pkg::ST_NOSPACE;
        if (cmd.prep)
        begin
            lo_reg     <= lo_cl;
            hi_reg     <= hi_cl;
            w_reg      <= lo_cl[IW-1:5];
            i_reg      <= '0;
            c_reg      <= '0;
            c_over_reg <= 1'b0;
            num_reg    <= num41_reg[NW-1:0];
        end
        if (cmd.scan_step)
        begin
            i_reg <= i_reg + NW'(1);
            if (cur_bit)
            begin
                c_reg      <= up;
                c_over_reg <= al_over;
            end
            if (found)
            begin
                lo_reg    <= c_reg;
                hi_reg    <= c_reg + num_reg;
                w_reg     <= c_reg[IW-1:5];
                gaddr_reg <= base_reg + (48'(c_reg) << log_block_reg);
            end
        end
        if (cmd.wr_rmw && !sts.rmw_last)
            w_reg <= w_reg + WA'(1);
    end

    // bitmap memory, one row valid bit per word
    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WA:0]      raddr, waddr;

    assign raddr = {pool_reg[0], cmd.rd_rmw ? w_reg : i_reg[IW-1:5]};
    assign waddr = {pool_reg[0], w_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.rd_scan || cmd.rd_rmw)
            rd_reg <= mem[raddr];
        if (cmd.wr_rmw)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.rd_scan || cmd.rd_rmw)
                rv_reg <= valid_reg[raddr];
            if (cmd.wr_rmw)
                valid_reg[waddr] <= 1'b1;
        end
    end

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [47:0] out_gaddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= status_reg;
            out_gaddr_reg  <= gaddr_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = {6'b0, out_gaddr_reg, out_status_reg};

    a_wr_mask: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_rmw |-> (wmask != '0))
        else $error("update word outside range");

    a_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && found) |->
            (({1'b0, c_reg} + {1'b0, num_reg}) <= {1'b0, maxb_reg}))
        else $error("run beyond pool");

    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten");

endmodule

// File: design/abba_ctrl.sv
module abba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output abba_pkg::cmd_t  cmd,
    input  abba_pkg::sts_t  sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_SC_RD  = 3'd3;
    localparam logic [2:0] S_SC_BIT = 3'd4;
    localparam logic [2:0] S_RMW_RD = 3'd5;
    localparam logic [2:0] S_RMW_WR = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                if (sts.err)
                    state_next = S_DONE;
                else if (sts.is_free)
                    state_next = sts.range_empty ? S_DONE : S_RMW_RD;
                else if (sts.no_fit)
                begin
                    cmd.set_nospace = 1'b1;
                    state_next      = S_DONE;
                end
                else
                    state_next = S_SC_RD;
            end
            S_SC_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_SC_BIT;
            end
            S_SC_BIT:
            begin
                cmd.scan_step = 1'b1;
                if (sts.found)
                    state_next = S_RMW_RD;
                else if (sts.scan_end)
                begin
                    cmd.set_nospace = 1'b1;
                    state_next      = S_DONE;
                end
                else if (sts.word_end)
                    state_next = S_SC_RD;
            end
            S_RMW_RD:
            begin
                cmd.rd_rmw = 1'b1;
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                cmd.wr_rmw = 1'b1;
                state_next = sts.rmw_last ? S_DONE : S_RMW_RD;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: design/aligned_bitmap_block_allocator_core.sv
// one request at a time; result registered after the check and prep steps plus the work below
// allocate scans the pool bitmap one block per cycle, plus one memory read per 32 blocks,
// then marks the granted run with a read and a write per bitmap word;
// free clears its range the same way; rejected requests go straight to the result
// reset clears both bitmaps at once through per-word valid bits, no clearing pass
module aligned_bitmap_block_allocator_core #(
    parameter int MAP_BITS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,    // kind, pool[1:0]
    input  logic [95:0] s_tdata,    // length[40:0], log_align[5:0], address[47:0], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // status[1:0], granted_address[47:0], pad
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_wdata
);

    abba_pkg::cmd_t cmd;
    abba_pkg::sts_t sts;

    abba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    abba_dp #(
        .MAP_BITS (MAP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        logic        kind;
        logic [1:0]  pool;
        logic [40:0] len;
        logic [5:0]  la;
        logic [47:0] addr;
    } alloc_req_t;

    typedef struct {
        logic [1:0]  status;
        logic [47:0] gaddr;
    } grant_t;

    typedef struct {
        logic [1:0]  pool;
        logic [47:0] addr;
        logic [40:0] len;
    } region_t;

    class alloc_scoreboard;
        grant_t  grant_q[$];
        region_t live_q[$];
        logic [47:0] base[2];
        logic [5:0]  log_size[2];
        logic [5:0]  lb;
        bit          occ[2][1024];
        int          errors;

        function new();
            base[0] = '0;
            base[1] = '0;
            log_size[0] = '0;
            log_size[1] = '0;
            lb = abba_pkg::LOG_BLOCK_RST;
            errors = 0;
            foreach (occ[p, i]) occ[p][i] = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [47:0] val);
            case (idx)
                abba_pkg::CFG_STEER_BASE:      base[0] = val;
                abba_pkg::CFG_STEER_LOG_SIZE:  log_size[0] = val[5:0];
                abba_pkg::CFG_MODIFY_BASE:     base[1] = val;
                abba_pkg::CFG_MODIFY_LOG_SIZE: log_size[1] = val[5:0];
                abba_pkg::CFG_LOG_BLOCK:       lb = val[5:0];
                default: ;
            endcase
        endfunction

        function longint unsigned pool_blocks(logic [5:0] lsz);
            longint unsigned e;
            if (lsz < lb) return 0;
            e = lsz - lb;
            if (e >= 10) return 1024;
            return 64'd1 << e;
        endfunction

        function void note_request(alloc_req_t rq);
            longint unsigned bsize, maxb, num, step, start, first, la, i;
            int p;
            bit fits;
            grant_t g;
            region_t r;
            g.status = abba_pkg::ST_OK;
            g.gaddr = '0;
            bsize = 64'd1 << lb;
            if (rq.kind == abba_pkg::KIND_ALLOC && (rq.len == 0 || (rq.len & (rq.len - 1)) != 0
                    || ({23'd0, rq.len} & (bsize - 1)) != 0))
                g.status = abba_pkg::ST_INVALID;
            else if (rq.pool > 1)
                g.status = abba_pkg::ST_INVALID;
            else if (base[rq.pool] == 0)
                g.status = abba_pkg::ST_UNSUPPORTED;
            else
            begin
                p = rq.pool;
                maxb = pool_blocks(log_size[p]);
                if (rq.kind == abba_pkg::KIND_ALLOC)
                begin
                    num = rq.len >> lb;
                    la = (rq.la < lb) ? lb : rq.la;
                    step = 64'd1 << (la - lb);
                    g.status = abba_pkg::ST_NOSPACE;
                    for (start = 0; start < maxb && num <= maxb - start; start += step)
                    begin
                        fits = 1;
                        for (i = 0; i < num; i++)
                            if (occ[p][start + i]) fits = 0;
                        if (fits)
                        begin
                            for (i = 0; i < num; i++) occ[p][start + i] = 1;
                            g.status = abba_pkg::ST_OK;
                            g.gaddr = 48'(base[p] + (start << lb));
                            r.pool = rq.pool;
                            r.addr = g.gaddr;
                            r.len = rq.len;
                            live_q.push_back(r);
                            break;
                        end
                    end
                end
                else
                begin
                    first = ({16'd0, rq.addr} - {16'd0, base[p]}) >> lb;
                    num = (rq.len >> lb) + ((({23'd0, rq.len} & (bsize - 1)) != 0) ? 1 : 0);
                    for (i = 0; i < maxb; i++)
                        if (i >= first && i - first < num) occ[p][i] = 0;
                end
            end
            grant_q.push_back(g);
        endfunction

        function void check_grant(logic [1:0] status, logic [47:0] gaddr);
            grant_t g;
            if (grant_q.size() == 0)
            begin
                $display("%0t: unexpected response status %0d addr %h", $time, status, gaddr);
                errors++;
                return;
            end
            g = grant_q.pop_front();
            if (g.status !== status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, g.status, status);
                errors++;
            end
            if (g.gaddr !== gaddr)
            begin
                $display("%0t: address expected %h actual %h", $time, g.gaddr, gaddr);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [2:0]  s_tuser;    // kind, pool[1:0]
    logic [95:0] s_tdata;    // length[40:0], log_align[5:0], address[47:0], pad
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;    // status[1:0], granted_address[47:0], pad
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_wdata;

    alloc_scoreboard sb;
    bit calm;
    bit hold_req;

    aligned_bitmap_block_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    initial
    begin
        #200_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // response side
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_grant(m_tdata[1:0], m_tdata[49:2]);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                hold_req = 0;
                repeat (400) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_request(alloc_req_t rq);
        s_tvalid <= 1'b1;
        s_tuser  <= {rq.pool, rq.kind};
        s_tdata  <= {1'b0, rq.addr, rq.la, rq.len};
        do @(posedge clk); while (!s_tready);
        sb.note_request(rq);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.grant_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic apply_config(logic [47:0] sb_base, logic [5:0] s_log,
                                logic [47:0] md_base, logic [5:0] m_log, logic [5:0] lbv);
        logic [47:0] vals[5];
        vals = '{sb_base, {42'd0, s_log}, md_base, {42'd0, m_log}, {42'd0, lbv}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_wdata <= vals[i];
            @(posedge clk);
            sb.set_reg(i[2:0], vals[i]);
        end
        cfg_we <= 1'b0;
        sb.live_q.delete();
        @(posedge clk);
    endtask

    function automatic alloc_req_t make_req(logic kind, logic [1:0] pool, logic [40:0] len,
                                            logic [5:0] la, logic [47:0] addr);
        alloc_req_t rq;
        rq.kind = kind;
        rq.pool = pool;
        rq.len  = len;
        rq.la   = la;
        rq.addr = addr;
        return rq;
    endfunction

    function automatic alloc_req_t random_request();
        alloc_req_t rq;
        int idx, k;
        rq.pool = ($urandom_range(0, 99) < 6) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
        rq.la   = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, sb.lb + 3))
                                              : 6'($urandom_range(0, 63));
        rq.addr = 48'({$urandom, $urandom});
        rq.len  = 41'({$urandom, $urandom});
        if (sb.live_q.size() != 0 && $urandom_range(0, 99) < 40)
        begin
            rq.kind = abba_pkg::KIND_FREE;
            if ($urandom_range(0, 9) < 7)
            begin
                idx = $urandom_range(0, sb.live_q.size() - 1);
                rq.pool = sb.live_q[idx].pool;
                rq.addr = sb.live_q[idx].addr;
                rq.len  = sb.live_q[idx].len;
                sb.live_q.delete(idx);
            end
            else if ($urandom_range(0, 1) == 0)
                rq.len = rq.len >> $urandom_range(20, 40);
        end
        else
        begin
            rq.kind = abba_pkg::KIND_ALLOC;
            k = sb.lb + $urandom_range(0, 3);
            if (k > 40) k = 40;
            if ($urandom_range(0, 99) < 85)
                rq.len = 41'd1 << k;
            else if ($urandom_range(0, 1) == 0)
                rq.len = 41'd1 << $urandom_range(0, 40);
        end
        return rq;
    endfunction

    task automatic random_run(int n);
        repeat (n) send_request(random_request());
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        calm = 0;
        hold_req = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // pools absent after reset; also invalid pools and lengths
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd0, 41'd4096, 6'd0, '0));
        send_request(make_req(abba_pkg::KIND_FREE, 2'd1, 41'd4096, 6'd0, 48'h1000));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd2, 41'd4096, 6'd0, '0));
        send_request(make_req(abba_pkg::KIND_FREE, 2'd3, 41'd4096, 6'd0, '0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd0, 41'd0, 6'd0, '0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd0, 41'd6144, 6'd0, '0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd1, 41'd2048, 6'd0, '0));
        wait_idle();

        apply_config(48'h1_0000_0000, 6'd18, 48'hFFFF_FFFF_F000, 6'd16, 6'd12);
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd0, 41'd4096, 6'd63, '0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd0, 41'd4096, 6'd63, '0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd0, 41'd16384, 6'd14, '0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd1, 41'd8192, 6'd0, '0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd1, 41'd65536, 6'd0, '0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd1, 41'h100_0000_0000, 6'd0, '0));
        send_request(make_req(abba_pkg::KIND_FREE, 2'd0, 41'd1, 6'd0, 48'h1_0000_0000));
        send_request(make_req(abba_pkg::KIND_FREE, 2'd1, 41'h1FF_FFFF_FFFF, 6'd63,
                              48'hFFFF_FFFF_FFFF));
        send_request(make_req(abba_pkg::KIND_FREE, 2'd0, 41'd4096, 6'd0, 48'h0));
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd0, 41'd262144, 6'd0, '0));
        wait_idle();
        hold_req = 1;
        random_run(400);
        wait_idle();

        apply_config(48'h1, 6'd4, 48'hFFFF_FFFF_FFFF, 6'd0, 6'd0);
        random_run(350);
        wait_idle();

        apply_config(48'({$urandom, $urandom}) | 48'h1, 6'd63, 48'h8000_0000_0000, 6'd39,
                     6'd40);
        send_request(make_req(abba_pkg::KIND_ALLOC, 2'd1, 41'h100_0000_0000, 6'd0, '0));
        random_run(200);
        wait_idle();

        apply_config(48'({$urandom, $urandom}) | 48'h1, 6'd63,
                     48'({$urandom, $urandom}) | 48'h1, 6'd63, 6'd5);
        random_run(200);
        calm = 1;
        random_run(300);
        wait_idle();

        if (sb.errors == 0 && sb.grant_q.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
